>>> design/ldt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ldt_pkg: shared types and constants of the lexer transition engine
// Holds the channel payload structs, the decoded operation passed from the
// front end to the back end, and the class, kind and error codes.
// ----------------------------------------------------------------------------
package ldt_pkg;

  // Table geometry.
  localparam int MAX_STATES   = 64;
  localparam int STATE_W      = 6;
  localparam int CHAR_W       = 8;
  localparam int CHAR_ADDR_W  = STATE_W + CHAR_W;
  localparam int CHAR_DEPTH   = MAX_STATES * (2 ** CHAR_W);
  localparam int NUM_CLASSES  = 9;
  localparam int CLS_W        = 4;
  localparam int ENTRY_W      = STATE_W + 1;
  localparam int KIND_W       = 2;
  localparam int COUNT_W      = 7;

  // Decoupling queue.
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = 2;
  localparam int QCNT_W       = 3;

  // Register reset value.
  localparam logic [COUNT_W-1:0] STATE_COUNT_RST = 7'd64;

  // Request kinds on the input channel.
  localparam logic [1:0] KIND_CHAR_WR  = 2'd0;
  localparam logic [1:0] KIND_CLASS_WR = 2'd1;
  localparam logic [1:0] KIND_STATE_WR = 2'd2;
  localparam logic [1:0] KIND_STEP     = 2'd3;

  // State kinds; the spare code behaves as a normal state.
  localparam logic [KIND_W-1:0] STATE_NORMAL  = 2'd0;
  localparam logic [KIND_W-1:0] STATE_INITIAL = 2'd1;
  localparam logic [KIND_W-1:0] STATE_FINAL   = 2'd2;
  localparam logic [KIND_W-1:0] STATE_SPARE   = 2'd3;

  // Character classes.
  localparam logic [CLS_W-1:0] CLS_LOWER    = 4'd0;
  localparam logic [CLS_W-1:0] CLS_UPPER    = 4'd1;
  localparam logic [CLS_W-1:0] CLS_POSITIVE = 4'd2;
  localparam logic [CLS_W-1:0] CLS_EOF      = 4'd3;
  localparam logic [CLS_W-1:0] CLS_NEWLINE  = 4'd4;
  localparam logic [CLS_W-1:0] CLS_RETURN   = 4'd5;
  localparam logic [CLS_W-1:0] CLS_SPACE    = 4'd6;
  localparam logic [CLS_W-1:0] CLS_TAB      = 4'd7;
  localparam logic [CLS_W-1:0] CLS_OTHER    = 4'd8;
  localparam logic [CLS_W-1:0] CLS_NONE     = 4'd9;

  // Error codes.
  localparam logic [1:0] ERR_OK       = 2'd0;
  localparam logic [1:0] ERR_RANGE    = 2'd1;
  localparam logic [1:0] ERR_FINAL    = 2'd2;
  localparam logic [1:0] ERR_NO_OTHER = 2'd3;

  // Input request payload.
  typedef struct packed {
    logic [1:0]         kind;
    logic [STATE_W-1:0] state_id;
    logic [CHAR_W-1:0]  char_code;
    logic               is_eof;
    logic [CLS_W-1:0]   class_index;
    logic [STATE_W-1:0] target_state;
    logic               entry_valid;
    logic [KIND_W-1:0]  state_kind;
  } in_item_t;

  // Result payload.
  typedef struct packed {
    logic [STATE_W-1:0] next_state;
    logic [1:0]         error_code;
  } out_item_t;

  // Decoded operation handed to the back end.
  typedef enum logic [1:0] {
    OP_CHAR_WR  = 2'd0,
    OP_CLASS_WR = 2'd1,
    OP_KIND_WR  = 2'd2,
    OP_STEP     = 2'd3
  } op_kind_e;

  typedef struct packed {
    op_kind_e           op;
    logic [STATE_W-1:0] state_id;
    logic [CHAR_W-1:0]  char_code;
    logic [CLS_W-1:0]   cls;
    logic               use_char;
    logic               out_of_range;
    logic [ENTRY_W-1:0] entry;
    logic [KIND_W-1:0]  state_kind;
  } op_t;

endpackage : ldt_pkg
`default_nettype wire

>>> design/lexer_dfa_transition_table_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lexer_dfa_transition_table_core: programmable lexer automaton transitions
// Table writes and step requests enter a decoder, pass a short queue and
// reach the table back end, which returns one result per step.
//
//   Channel  Signals                           Moves
//   in       in_valid_i / in_stall_o / in_data_i   one request (write or step)
//   out      out_valid_o / out_stall_i / out_data_o one step result
//   cfg      cfg_we_i / cfg_data_i                  state count register
//
// One request per cycle is taken while no clearing pass or full queue stalls
// the input; a step result passes the queue, the table read registers and
// the output register. After reset a clearing pass walks the 16384-entry
// character table, one entry a cycle, and clears the class and kind tables
// on the way; in_stall_o is high while it runs.
// A stall on the output fills the queue and then raises in_stall_o.
// ----------------------------------------------------------------------------
module lexer_dfa_transition_table_core (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                cfg_we_i,
  input  wire  [ldt_pkg::COUNT_W-1:0]        cfg_data_i,
  input  wire                                in_valid_i,
  output logic                               in_stall_o,
  input  ldt_pkg::in_item_t                  in_data_i,
  output logic                               out_valid_o,
  input  wire                                out_stall_i,
  output ldt_pkg::out_item_t                 out_data_o
);

  logic         accept;
  logic         push, pop, q_full, q_empty, busy;
  ldt_pkg::op_t push_op, pop_op;

  // Accept a request when the queue has room and no clearing runs.
  assign in_stall_o = q_full || busy;
  assign accept     = in_valid_i && !in_stall_o;

  ldt_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .accept_i   (accept),
    .item_i     (in_data_i),
    .push_o     (push),
    .op_o       (push_op)
  );

  ldt_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_op_i (push_op),
    .pop_i     (pop),
    .pop_op_o  (pop_op),
    .full_o    (q_full),
    .empty_o   (q_empty)
  );

  ldt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_op_i      (pop_op),
    .q_pop_o     (pop),
    .busy_o      (busy),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_data_o),
    .out_stall_i (out_stall_i)
  );

endmodule : lexer_dfa_transition_table_core
`default_nettype wire

>>> design/ldt_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ldt_front: request decoder and classifier
// Holds the state count register, classifies the character of a step,
// checks the state range and turns each accepted request into an operation.
// ----------------------------------------------------------------------------
module ldt_front (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                cfg_we_i,
  input  wire  [ldt_pkg::COUNT_W-1:0]        cfg_data_i,
  input  wire                                accept_i,
  input  ldt_pkg::in_item_t                  item_i,
  output logic                               push_o,
  output ldt_pkg::op_t                       op_o
);

  logic [ldt_pkg::COUNT_W-1:0] state_count_q;
  logic [ldt_pkg::CLS_W-1:0]   char_cls;

  // Character class of a byte, none if it belongs to no named class.
  function automatic logic [ldt_pkg::CLS_W-1:0] class_of_char(
    input logic [ldt_pkg::CHAR_W-1:0] c
  );
    logic [ldt_pkg::CLS_W-1:0] r;
    r = ldt_pkg::CLS_NONE;
    if (c >= 8'h61 && c <= 8'h7a) begin
      r = ldt_pkg::CLS_LOWER;
    end else if (c >= 8'h41 && c <= 8'h5a) begin
      r = ldt_pkg::CLS_UPPER;
    end else if (c >= 8'h31 && c <= 8'h39) begin
      r = ldt_pkg::CLS_POSITIVE;
    end else if (c == 8'h0a) begin
      r = ldt_pkg::CLS_NEWLINE;
    end else if (c == 8'h0d) begin
      r = ldt_pkg::CLS_RETURN;
    end else if (c == 8'h20) begin
      r = ldt_pkg::CLS_SPACE;
    end else if (c == 8'h09) begin
      r = ldt_pkg::CLS_TAB;
    end
    return r;
  endfunction

  // State count register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_count_q <= ldt_pkg::STATE_COUNT_RST;
    end else if (cfg_we_i) begin
      state_count_q <= cfg_data_i;
    end
  end

  assign char_cls = class_of_char(item_i.char_code);

  // Decode the request into an operation for the back end.
  always_comb begin
    op_o.state_id     = item_i.state_id;
    op_o.char_code    = item_i.char_code;
    op_o.entry        = item_i.entry_valid ? {1'b1, item_i.target_state} : '0;
    op_o.state_kind   = item_i.state_kind;
    op_o.use_char     = !item_i.is_eof;
    op_o.out_of_range = {1'b0, item_i.state_id} >= state_count_q;
    op_o.cls          = item_i.class_index;
    op_o.op           = ldt_pkg::OP_STEP;
    push_o            = accept_i;
    unique case (item_i.kind)
      ldt_pkg::KIND_CHAR_WR: begin
        op_o.op = ldt_pkg::OP_CHAR_WR;
      end
      ldt_pkg::KIND_CLASS_WR: begin
        op_o.op = ldt_pkg::OP_CLASS_WR;
        // Writes to a class beyond OTHER are dropped here.
        push_o  = accept_i && (item_i.class_index <= ldt_pkg::CLS_OTHER);
      end
      ldt_pkg::KIND_STATE_WR: begin
        op_o.op = ldt_pkg::OP_KIND_WR;
      end
      ldt_pkg::KIND_STEP: begin
        op_o.op  = ldt_pkg::OP_STEP;
        op_o.cls = item_i.is_eof ? ldt_pkg::CLS_EOF : char_cls;
      end
      default: begin
        op_o.op = ldt_pkg::OP_STEP;
      end
    endcase
  end

endmodule : ldt_front
`default_nettype wire

>>> design/ldt_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ldt_queue: short queue between the front end and the back end
// A four-entry FIFO of decoded operations so that each side stalls alone.
// ----------------------------------------------------------------------------
module ldt_queue (
  input  wire           clk_i,
  input  wire           rst_ni,
  input  wire           push_i,
  input  ldt_pkg::op_t  push_op_i,
  input  wire           pop_i,
  output ldt_pkg::op_t  pop_op_o,
  output logic          full_o,
  output logic          empty_o
);

  ldt_pkg::op_t                entries_q [ldt_pkg::QUEUE_DEPTH];
  logic [ldt_pkg::QPTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [ldt_pkg::QPTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [ldt_pkg::QCNT_W-1:0]  count_q, count_d;
  logic                        do_push, do_pop;

  assign full_o   = count_q == ldt_pkg::QCNT_W'(ldt_pkg::QUEUE_DEPTH);
  assign empty_o  = count_q == '0;
  assign do_push  = push_i && !full_o;
  assign do_pop   = pop_i && !empty_o;
  assign pop_op_o = entries_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_op_i;
    end
  end

endmodule : ldt_queue
`default_nettype wire

>>> design/ldt_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ldt_back: table storage and transition select
// Owns the character, class and state kind tables, clears them after reset,
// performs writes, reads the tables for a step and picks the next state by
// priority into an output register.
// ----------------------------------------------------------------------------
module ldt_back (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 q_empty_i,
  input  ldt_pkg::op_t        q_op_i,
  output logic                q_pop_o,
  output logic                busy_o,
  output logic                out_valid_o,
  output ldt_pkg::out_item_t  out_item_o,
  input  wire                 out_stall_i
);

  // Clearing pass.
  logic [ldt_pkg::CHAR_ADDR_W-1:0] clr_cnt_q;
  logic                            clr_busy_q;
  logic                            clr_row;

  // Handshake inside the back end.
  logic out_free, b_free, issue_step;

  // Table write ports.
  logic                            char_we;
  logic [ldt_pkg::CHAR_ADDR_W-1:0] char_waddr;
  logic [ldt_pkg::ENTRY_W-1:0]     char_wdata;
  logic [ldt_pkg::STATE_W-1:0]     row_waddr;
  logic [ldt_pkg::ENTRY_W-1:0]     cls_wdata;
  logic                            kind_we;
  logic [ldt_pkg::KIND_W-1:0]      kind_wdata;

  // Table storage and registered reads.
  logic [ldt_pkg::ENTRY_W-1:0] char_mem_q [ldt_pkg::CHAR_DEPTH];
  logic [ldt_pkg::KIND_W-1:0]  kind_mem_q [ldt_pkg::MAX_STATES];
  logic [ldt_pkg::ENTRY_W-1:0] char_rd_q;
  logic [ldt_pkg::KIND_W-1:0]  kind_rd_q;
  logic [ldt_pkg::ENTRY_W-1:0] cls_rd_q [ldt_pkg::NUM_CLASSES];

  // Select stage.
  logic                        b_valid_q;
  logic [ldt_pkg::CLS_W-1:0]   b_cls_q;
  logic                        b_use_char_q;
  logic                        b_oor_q;
  logic [ldt_pkg::ENTRY_W-1:0] cls_e, other_e;
  ldt_pkg::out_item_t          res;

  // Output register.
  logic               out_valid_q;
  ldt_pkg::out_item_t out_item_q;

  // Sweep every table once after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q  <= '0;
      clr_busy_q <= 1'b1;
    end else if (clr_busy_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (clr_cnt_q == '1) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  assign clr_row = clr_cnt_q[ldt_pkg::CHAR_ADDR_W-1:ldt_pkg::STATE_W] == '0;
  assign busy_o  = clr_busy_q;

  // Take an operation when the select stage can hold its result.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign b_free     = !b_valid_q || out_free;
  assign q_pop_o    = !clr_busy_q && !q_empty_i && b_free;
  assign issue_step = q_pop_o && (q_op_i.op == ldt_pkg::OP_STEP);

  // Write port muxing between the clearing pass and table writes.
  always_comb begin
    char_we    = clr_busy_q || (q_pop_o && q_op_i.op == ldt_pkg::OP_CHAR_WR);
    char_waddr = clr_busy_q ? clr_cnt_q : {q_op_i.state_id, q_op_i.char_code};
    char_wdata = clr_busy_q ? '0 : q_op_i.entry;
    row_waddr  = clr_busy_q ? clr_cnt_q[ldt_pkg::STATE_W-1:0] : q_op_i.state_id;
    cls_wdata  = clr_busy_q ? '0 : q_op_i.entry;
    kind_we    = clr_busy_q ? clr_row : (q_pop_o && q_op_i.op == ldt_pkg::OP_KIND_WR);
    kind_wdata = clr_busy_q ? '0 : q_op_i.state_kind;
  end

  // Exact character table.
  always_ff @(posedge clk_i) begin
    if (char_we) begin
      char_mem_q[char_waddr] <= char_wdata;
    end
    if (issue_step) begin
      char_rd_q <= char_mem_q[{q_op_i.state_id, q_op_i.char_code}];
    end
  end

  // State kind table.
  always_ff @(posedge clk_i) begin
    if (kind_we) begin
      kind_mem_q[row_waddr] <= kind_wdata;
    end
    if (issue_step) begin
      kind_rd_q <= kind_mem_q[q_op_i.state_id];
    end
  end

  // One class table per class, all read at the current state.
  for (genvar g = 0; g < ldt_pkg::NUM_CLASSES; g++) begin : g_cls
    logic [ldt_pkg::ENTRY_W-1:0] mem_q [ldt_pkg::MAX_STATES];
    logic                        we;

    assign we = clr_busy_q ? clr_row
              : (q_pop_o && q_op_i.op == ldt_pkg::OP_CLASS_WR &&
                 q_op_i.cls == ldt_pkg::CLS_W'(g));

    always_ff @(posedge clk_i) begin
      if (we) begin
        mem_q[row_waddr] <= cls_wdata;
      end
      if (issue_step) begin
        cls_rd_q[g] <= mem_q[q_op_i.state_id];
      end
    end
  end

  // Select stage control and step fields.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (b_free) begin
      b_valid_q <= issue_step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue_step) begin
      b_cls_q      <= q_op_i.cls;
      b_use_char_q <= q_op_i.use_char;
      b_oor_q      <= q_op_i.out_of_range;
    end
  end

  // Priority select: range error, final state, exact character, class, then OTHER.
  always_comb begin
    cls_e   = (b_cls_q < ldt_pkg::CLS_OTHER) ? cls_rd_q[b_cls_q] : '0;
    other_e = cls_rd_q[ldt_pkg::CLS_OTHER];
    res.next_state = '0;
    res.error_code = ldt_pkg::ERR_OK;
    priority if (b_oor_q) begin
      res.error_code = ldt_pkg::ERR_RANGE;
    end else if (kind_rd_q == ldt_pkg::STATE_FINAL) begin
      res.error_code = ldt_pkg::ERR_FINAL;
    end else if (b_use_char_q && char_rd_q[ldt_pkg::STATE_W]) begin
      res.next_state = char_rd_q[ldt_pkg::STATE_W-1:0];
    end else if (cls_e[ldt_pkg::STATE_W]) begin
      res.next_state = cls_e[ldt_pkg::STATE_W-1:0];
    end else if (other_e[ldt_pkg::STATE_W]) begin
      res.next_state = other_e[ldt_pkg::STATE_W-1:0];
    end else begin
      res.error_code = ldt_pkg::ERR_NO_OTHER;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && b_valid_q) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule : ldt_back
`default_nettype wire

>>> design/ldt_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ldt_checker: port-level checks of the lexer transition engine
// Watches the top-level ports and is bound to the top level below.
// ----------------------------------------------------------------------------
module ldt_checker (
  input wire                           clk_i,
  input wire                           rst_ni,
  input wire                           in_valid_i,
  input wire                           in_stall_o,
  input ldt_pkg::in_item_t             in_data_i,
  input wire                           out_valid_o,
  input wire                           out_stall_i,
  input ldt_pkg::out_item_t            out_data_o
);

  // A stalled request stays offered with the same payload.
  a_in_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_data_i))
    else $error("request changed while stalled");

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its value.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("result changed while stalled");

  // Every error reports state zero.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.error_code != ldt_pkg::ERR_OK |->
      out_data_o.next_state == '0)
    else $error("error result with nonzero next state");

  // The table clearing pass holds off requests right after reset.
  a_clear_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!rst_ni) |-> in_stall_o)
    else $error("request accepted during table clearing");

endmodule : ldt_checker

bind lexer_dfa_transition_table_core ldt_checker u_ldt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
`default_nettype wire
